@@ design/tsf_pkg.sv @@
// ---------------------------------------------------------------------------
// tsf_pkg: shared types and constants for the triangle scanline filler
// Coordinate widths, command codes and the edge unit request/response bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsf_pkg;

    // coordinate and color widths
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;

    // magnitude of (b - a) * dy fits in twice the coordinate width
    localparam int PROD_BITS  = 2 * COORD_BITS;

    // divider step counter, counts COORD_BITS-1 down to zero
    localparam int STEP_BITS  = $clog2(COORD_BITS);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ucoord_t;
    typedef logic        [COLOR_BITS-1:0] color_t;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // request to the edge interpolation unit
    typedef struct packed {
        logic    start;
        coord_t  a;
        coord_t  b;
        ucoord_t dy;
        ucoord_t h;
    } edge_req_t;

    // response from the edge interpolation unit
    typedef struct packed {
        logic   done;
        coord_t x;
    } edge_rsp_t;

endpackage

@@ design/triangle_scanline_filler.sv @@
// ---------------------------------------------------------------------------
// triangle_scanline_filler: span generator for a y-sorted triangle
// Loads a triangle, then hands out one horizontal span per step command.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries a command. A load command
//   sorts the three vertices by y and stores them with the fill color; it
//   produces no output. A step command produces exactly one output transfer:
//   the next span from the top row down to the bottom row, with last_span
//   set on the bottom row, or span_valid 0 / last_span 1 if nothing is held.
//   A load while spans remain drops the old triangle.
// Timing:
//   Each span interpolates its long and short edges on one shared edge unit
//   (issue, multiply, restoring divide, add). A step holds the input until
//   its result is in the output register; flat triangles and empty steps
//   skip the edge unit, and a load does not hold the input. in_stall is
//   high while a step is in progress.
// Reset and back pressure:
//   rst_n drops the held triangle and empties the output register. While
//   out_stall holds a result, the next command is still taken; a finished span
//   then waits in a holding register until the output register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_scanline_filler (
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  tsf_pkg::coord_t         v0_x,
    input  tsf_pkg::coord_t         v0_y,
    input  tsf_pkg::coord_t         v1_x,
    input  tsf_pkg::coord_t         v1_y,
    input  tsf_pkg::coord_t         v2_x,
    input  tsf_pkg::coord_t         v2_y,
    input  tsf_pkg::color_t         fill_color,
    // span channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output tsf_pkg::coord_t         span_row,
    output tsf_pkg::coord_t         x_left,
    output tsf_pkg::coord_t         x_right,
    output tsf_pkg::color_t         span_color,
    output logic                    span_valid,
    output logic                    last_span
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LONG  = 4'b0010,
        ST_SHORT = 4'b0100,
        ST_DONE  = 4'b1000
    } fill_state_t;

    fill_state_t state_reg, state_next;
    logic        pending_reg, pending_next;
    logic        out_valid_reg, out_valid_next;

    tsf_pkg::coord_t row_reg, row_next;
    tsf_pkg::coord_t vx_reg [3];
    tsf_pkg::coord_t vy_reg [3];
    tsf_pkg::coord_t vx_next [3];
    tsf_pkg::coord_t vy_next [3];
    tsf_pkg::color_t color_reg, color_next;
    tsf_pkg::coord_t xa_reg, xa_next;

    // holding register for a finished span
    tsf_pkg::coord_t res_row_reg, res_row_next;
    tsf_pkg::coord_t res_xl_reg, res_xl_next;
    tsf_pkg::coord_t res_xr_reg, res_xr_next;
    tsf_pkg::color_t res_color_reg, res_color_next;
    logic            res_valid_reg, res_valid_next;
    logic            res_last_reg, res_last_next;

    // output register
    tsf_pkg::coord_t out_row_reg, out_row_next;
    tsf_pkg::coord_t out_xl_reg, out_xl_next;
    tsf_pkg::coord_t out_xr_reg, out_xr_next;
    tsf_pkg::color_t out_color_reg, out_color_next;
    logic            out_span_valid_reg, out_span_valid_next;
    logic            out_last_reg, out_last_next;

    tsf_pkg::edge_req_t edge_req;
    tsf_pkg::edge_rsp_t edge_rsp;

    logic            accept;
    logic            flat;
    logic            upper;
    logic            last;
    logic            finish;
    tsf_pkg::coord_t sx [3];
    tsf_pkg::coord_t sy [3];
    tsf_pkg::coord_t fmin, fmax;
    tsf_pkg::coord_t ea, eb;

    // difference of two coordinates, known to be non-negative here
    function automatic tsf_pkg::ucoord_t cdiff(tsf_pkg::coord_t p, tsf_pkg::coord_t q);
        logic signed [tsf_pkg::COORD_BITS:0] d;
        d = $signed({p[tsf_pkg::COORD_BITS-1], p}) - $signed({q[tsf_pkg::COORD_BITS-1], q});
        return d[tsf_pkg::COORD_BITS-1:0];
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // sort incoming vertices by y; equal y need not keep input order
    always_comb
    begin
        tsf_pkg::coord_t tx, ty;
        tx = '0;
        ty = '0;
        sx[0] = v0_x; sy[0] = v0_y;
        sx[1] = v1_x; sy[1] = v1_y;
        sx[2] = v2_x; sy[2] = v2_y;
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
        if (sy[0] > sy[2])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[2]; sy[0] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        if (sy[1] > sy[2])
        begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
    end

    // triangle geometry for the current row
    assign flat  = (vy_reg[0] == vy_reg[2]);
    assign upper = (row_reg < vy_reg[1]);
    assign last  = (row_reg >= vy_reg[2]);

    // flat triangle extent
    always_comb
    begin
        fmin = vx_reg[0];
        fmax = vx_reg[0];
        if (vx_reg[1] < fmin) fmin = vx_reg[1];
        if (vx_reg[2] < fmin) fmin = vx_reg[2];
        if (vx_reg[1] > fmax) fmax = vx_reg[1];
        if (vx_reg[2] > fmax) fmax = vx_reg[2];
    end

    // edge unit request: long edge from idle, short edge after the long one
    always_comb
    begin
        edge_req.start = (state_reg == ST_IDLE && accept && command == tsf_pkg::CMD_STEP
                          && pending_reg && !flat)
                       || (state_reg == ST_LONG && edge_rsp.done);
        if (state_reg == ST_IDLE)
        begin
            edge_req.a  = vx_reg[0];
            edge_req.b  = vx_reg[2];
            edge_req.dy = cdiff(row_reg, vy_reg[0]);
            edge_req.h  = cdiff(vy_reg[2], vy_reg[0]);
        end
        else if (upper)
        begin
            edge_req.a  = vx_reg[0];
            edge_req.b  = vx_reg[1];
            edge_req.dy = cdiff(row_reg, vy_reg[0]);
            edge_req.h  = cdiff(vy_reg[1], vy_reg[0]);
        end
        else
        begin
            edge_req.a  = vx_reg[1];
            edge_req.b  = vx_reg[2];
            edge_req.dy = cdiff(row_reg, vy_reg[1]);
            edge_req.h  = cdiff(vy_reg[2], vy_reg[1]);
        end
    end

    tsf_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (edge_req),
        .rsp   (edge_rsp)
    );

    // span end points in order
    always_comb
    begin
        if (flat)
        begin
            ea = fmin;
            eb = fmax;
        end
        else if (xa_reg > edge_rsp.x)
        begin
            ea = edge_rsp.x;
            eb = xa_reg;
        end
        else
        begin
            ea = xa_reg;
            eb = edge_rsp.x;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        row_next       = row_reg;
        color_next     = color_reg;
        xa_next        = xa_reg;
        for (int i = 0; i < 3; i++)
        begin
            vx_next[i] = vx_reg[i];
            vy_next[i] = vy_reg[i];
        end
        res_row_next   = res_row_reg;
        res_xl_next    = res_xl_reg;
        res_xr_next    = res_xr_reg;
        res_color_next = res_color_reg;
        res_valid_next = res_valid_reg;
        res_last_next  = res_last_reg;
        out_row_next        = out_row_reg;
        out_xl_next         = out_xl_reg;
        out_xr_next         = out_xr_reg;
        out_color_next      = out_color_reg;
        out_span_valid_next = out_span_valid_reg;
        out_last_next       = out_last_reg;
        out_valid_next      = out_valid_reg && out_stall;
        finish         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == tsf_pkg::CMD_LOAD)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            vx_next[i] = sx[i];
                            vy_next[i] = sy[i];
                        end
                        color_next   = fill_color;
                        row_next     = sy[0];
                        pending_next = 1'b1;
                    end
                    else if (!pending_reg)
                    begin
                        res_row_next   = '0;
                        res_xl_next    = '0;
                        res_xr_next    = '0;
                        res_color_next = '0;
                        res_valid_next = 1'b0;
                        res_last_next  = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (flat)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LONG;
                    end
                end
            end
            ST_LONG:
            begin
                if (edge_rsp.done)
                begin
                    xa_next    = edge_rsp.x;
                    state_next = ST_SHORT;
                end
            end
            ST_SHORT:
            begin
                if (edge_rsp.done)
                begin
                    finish = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_row_next        = res_row_reg;
                    out_xl_next         = res_xl_reg;
                    out_xr_next         = res_xr_reg;
                    out_color_next      = res_color_reg;
                    out_span_valid_next = res_valid_reg;
                    out_last_next       = res_last_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capture a finished span and advance the row
        if (finish)
        begin
            res_row_next   = row_reg;
            res_xl_next    = ea;
            res_xr_next    = eb;
            res_color_next = color_reg;
            res_valid_next = 1'b1;
            res_last_next  = last;
            if (last)
            begin
                pending_next = 1'b0;
            end
            else
            begin
                row_next = row_reg + tsf_pkg::coord_t'(1);
            end
            state_next = ST_DONE;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
        end
    end

    // triangle and span registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vx_reg[i] <= vx_next[i];
            vy_reg[i] <= vy_next[i];
        end
        color_reg          <= color_next;
        xa_reg             <= xa_next;
        res_row_reg        <= res_row_next;
        res_xl_reg         <= res_xl_next;
        res_xr_reg         <= res_xr_next;
        res_color_reg      <= res_color_next;
        res_valid_reg      <= res_valid_next;
        res_last_reg       <= res_last_next;
        out_row_reg        <= out_row_next;
        out_xl_reg         <= out_xl_next;
        out_xr_reg         <= out_xr_next;
        out_color_reg      <= out_color_next;
        out_span_valid_reg <= out_span_valid_next;
        out_last_reg       <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign span_row   = out_row_reg;
    assign x_left     = out_xl_reg;
    assign x_right    = out_xr_reg;
    assign span_color = out_color_reg;
    assign span_valid = out_span_valid_reg;
    assign last_span  = out_last_reg;

    // an empty step always reports the end of the triangle
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !span_valid) |-> last_span)
        else $error("empty span transfer without last_span");

    // emitted spans are ordered left to right
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && span_valid) |-> (x_left <= x_right))
        else $error("span with x_left beyond x_right");

    // edge results only arrive while an edge is being computed
    a_edge_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        edge_rsp.done |-> (state_reg == ST_LONG || state_reg == ST_SHORT))
        else $error("edge unit finished outside an edge state");

    // a step with nothing held goes straight to the result stage
    a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == tsf_pkg::CMD_STEP && !pending_reg) |=> (state_reg == ST_DONE))
        else $error("empty step did not finish at once");

endmodule

@@ design/tsf_edge.sv @@
// ---------------------------------------------------------------------------
// tsf_edge: edge interpolation unit
// Computes a + (b - a) * dy / h, truncated toward zero, with a multiply
// state and a restoring divider that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsf_edge (
    input  logic               clk,
    input  logic               rst_n,
    input  tsf_pkg::edge_req_t req,
    output tsf_pkg::edge_rsp_t rsp
);

    typedef enum logic [3:0] {
        EU_IDLE = 4'b0001,
        EU_MUL  = 4'b0010,
        EU_DIV  = 4'b0100,
        EU_FIN  = 4'b1000
    } edge_state_t;

    edge_state_t state_reg, state_next;
    logic        done_reg, done_next;

    tsf_pkg::coord_t                      a_reg, a_next;
    logic signed [tsf_pkg::COORD_BITS:0]  diff_reg, diff_next;
    tsf_pkg::ucoord_t                     dy_reg, dy_next;
    tsf_pkg::ucoord_t                     h_reg, h_next;
    logic                                 neg_reg, neg_next;
    logic [tsf_pkg::PROD_BITS-1:0]        rem_reg, rem_next;
    logic [tsf_pkg::PROD_BITS-1:0]        dsh_reg, dsh_next;
    tsf_pkg::ucoord_t                     quo_reg, quo_next;
    logic [tsf_pkg::STEP_BITS-1:0]        cnt_reg, cnt_next;
    tsf_pkg::coord_t                      x_reg, x_next;

    logic signed [tsf_pkg::COORD_BITS:0]     dy_s;
    logic signed [2*tsf_pkg::COORD_BITS+1:0] prod;
    logic signed [2*tsf_pkg::COORD_BITS+1:0] prod_abs;
    logic [tsf_pkg::PROD_BITS:0]             sub;
    logic                                    ge;
    logic signed [tsf_pkg::COORD_BITS:0]     qext;
    logic signed [tsf_pkg::COORD_BITS:0]     sum;

    // multiplier, sign-magnitude split
    assign dy_s     = $signed({1'b0, dy_reg});
    assign prod     = diff_reg * dy_s;
    assign prod_abs = prod[2*tsf_pkg::COORD_BITS+1] ? -prod : prod;

    // divider trial subtract
    assign sub = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign ge  = ~sub[tsf_pkg::PROD_BITS];

    // restore sign and add the start point
    assign qext = $signed({1'b0, quo_reg});
    assign sum  = $signed({a_reg[tsf_pkg::COORD_BITS-1], a_reg}) + (neg_reg ? -qext : qext);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        diff_next  = diff_reg;
        dy_next    = dy_reg;
        h_next     = h_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        case (state_reg)
            EU_IDLE:
            begin
                if (req.start)
                begin
                    a_next    = req.a;
                    diff_next = $signed({req.b[tsf_pkg::COORD_BITS-1], req.b})
                              - $signed({req.a[tsf_pkg::COORD_BITS-1], req.a});
                    dy_next   = req.dy;
                    h_next    = req.h;
                    quo_next  = '0;
                    neg_next  = 1'b0;
                    // zero-height edge: result is the start x
                    state_next = (req.h == '0) ? EU_FIN : EU_MUL;
                end
            end
            EU_MUL:
            begin
                rem_next   = prod_abs[tsf_pkg::PROD_BITS-1:0];
                neg_next   = prod[2*tsf_pkg::COORD_BITS+1];
                dsh_next   = {1'b0, h_reg, {(tsf_pkg::COORD_BITS-1){1'b0}}};
                quo_next   = '0;
                cnt_next   = tsf_pkg::STEP_BITS'(tsf_pkg::COORD_BITS - 1);
                state_next = EU_DIV;
            end
            EU_DIV:
            begin
                if (ge)
                begin
                    rem_next = sub[tsf_pkg::PROD_BITS-1:0];
                end
                quo_next = {quo_reg[tsf_pkg::COORD_BITS-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0)
                begin
                    state_next = EU_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            EU_FIN:
            begin
                x_next     = sum[tsf_pkg::COORD_BITS-1:0];
                done_next  = 1'b1;
                state_next = EU_IDLE;
            end
            default:
            begin
                state_next = EU_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        diff_reg <= diff_next;
        dy_reg   <= dy_next;
        h_reg    <= h_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;

endmodule

@@ tb/triangle_scanline_filler_tb.sv @@
// ---------------------------------------------------------------------------
// triangle_scanline_filler_tb: self-checking bench for the scanline filler
// Runs a directed table of triangles, then random load/step sequences.
// Every span transfer is checked against a typed or predicted span, with
// random idling on both channels, a long output hold-off and a full drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_scanline_filler_tb;

    localparam int DIR_N        = 25;
    localparam int RAND_ITEMS   = 600;
    localparam int HOLD_AT      = DIR_N + 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_FROM   = DIR_N + 300;
    localparam int QUIET_TO     = DIR_N + 400;
    localparam int DRAIN_AT     = DIR_N + 450;
    localparam int STEP_CYCLES  = 2 * (tsf_pkg::COORD_BITS + 3) + 2;
    localparam int IDLE_PCT     = 23;

    // one command transfer
    typedef struct packed {
        logic            op;
        tsf_pkg::coord_t x0;
        tsf_pkg::coord_t y0;
        tsf_pkg::coord_t x1;
        tsf_pkg::coord_t y1;
        tsf_pkg::coord_t x2;
        tsf_pkg::coord_t y2;
        tsf_pkg::color_t color;
    } cmd_t;

    // one span transfer
    typedef struct packed {
        tsf_pkg::coord_t row;
        tsf_pkg::coord_t xl;
        tsf_pkg::coord_t xr;
        tsf_pkg::color_t color;
        logic            valid;
        logic            fin;
    } span_t;

    // directed row: command, and a typed span where it is obvious
    typedef struct packed {
        cmd_t  c;
        logic  typed;
        span_t want;
    } dir_row_t;

    localparam cmd_t  STEP         = '{tsf_pkg::CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0};
    localparam span_t NONE_PENDING = '{0, 0, 0, 32'h0, 1'b0, 1'b1};
    localparam span_t NO_SPAN      = '{0, 0, 0, 32'h0, 1'b0, 1'b0};

    localparam dir_row_t DIR_TAB [DIR_N] = '{
        // step with nothing loaded
        '{STEP, 1'b1, NONE_PENDING},
        // flat triangle, one span from min to max x
        '{'{tsf_pkg::CMD_LOAD, 7, 5, -3, 5, 20, 5, 32'hDEAD_BEEF}, 1'b0, NO_SPAN},
        '{STEP, 1'b1, '{5, -3, 20, 32'hDEAD_BEEF, 1'b1, 1'b1}},
        '{STEP, 1'b1, NONE_PENDING},
        // extreme corners, dropped after a few rows by the next load
        '{'{tsf_pkg::CMD_LOAD, -2048, -2048, 2047, 2047, -2048, 2047, 32'hFFFF_FFFF},
          1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        // unsorted flat top, then one step past the end
        '{'{tsf_pkg::CMD_LOAD, 10, 3, 0, 0, 4, 0, 32'h0000_0000}, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b1, NONE_PENDING},
        // flat bottom on the last row, widest edge slopes
        '{'{tsf_pkg::CMD_LOAD, 2047, 2040, -2048, 2047, 0, 2047, 32'h5A5A_A5A5},
          1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        '{STEP, 1'b0, NO_SPAN},
        // single point
        '{'{tsf_pkg::CMD_LOAD, 5, -7, 5, -7, 5, -7, 32'h0000_0001}, 1'b0, NO_SPAN},
        '{STEP, 1'b1, '{-7, 5, 5, 32'h0000_0001, 1'b1, 1'b1}}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    tsf_pkg::coord_t  v0_x;
    tsf_pkg::coord_t  v0_y;
    tsf_pkg::coord_t  v1_x;
    tsf_pkg::coord_t  v1_y;
    tsf_pkg::coord_t  v2_x;
    tsf_pkg::coord_t  v2_y;
    tsf_pkg::color_t  fill_color;
    logic             out_valid;
    logic             out_stall;
    tsf_pkg::coord_t  span_row;
    tsf_pkg::coord_t  x_left;
    tsf_pkg::coord_t  x_right;
    tsf_pkg::color_t  span_color;
    logic             span_valid;
    logic             last_span;

    // span predictor state
    int               tri_vx [3];
    int               tri_vy [3];
    int               tri_row;
    bit               tri_pending;
    tsf_pkg::color_t  tri_color;

    span_t   span_q [$];
    int      mismatch_count;
    int      items_sent;
    bit      quiet;
    bit      hold_req;

    triangle_scanline_filler dut (.*);

    always #5 clk = ~clk;

    // clear predictor state as after reset
    initial
    begin
        tri_vx      = '{0, 0, 0};
        tri_vy      = '{0, 0, 0};
        tri_row     = 0;
        tri_pending = 1'b0;
        tri_color   = '0;
    end

    // x on an edge at dy rows below its start, truncated toward zero
    function automatic int edge_interp(int a, int b, int dy, int h);
        longint p;
        if (h == 0)
            return a;
        p = longint'(b - a) * longint'(dy);
        return a + int'(p / longint'(h));
    endfunction

    function automatic void swap_vertex(int i, int j);
        int tx;
        int ty;
        tx = tri_vx[i];
        ty = tri_vy[i];
        tri_vx[i] = tri_vx[j];
        tri_vy[i] = tri_vy[j];
        tri_vx[j] = tx;
        tri_vy[j] = ty;
    endfunction

    // latch a triangle, sorted by y with the same swaps as the design
    function automatic void tri_load(cmd_t c);
        tri_vx = '{int'(c.x0), int'(c.x1), int'(c.x2)};
        tri_vy = '{int'(c.y0), int'(c.y1), int'(c.y2)};
        if (tri_vy[0] > tri_vy[1]) swap_vertex(0, 1);
        if (tri_vy[0] > tri_vy[2]) swap_vertex(0, 2);
        if (tri_vy[1] > tri_vy[2]) swap_vertex(1, 2);
        tri_color   = c.color;
        tri_row     = tri_vy[0];
        tri_pending = 1'b1;
    endfunction

    // next span of the held triangle, advancing the row
    function automatic span_t tri_step();
        span_t s;
        int    y;
        int    xa;
        int    xb;
        int    t;
        s = '0;
        if (!tri_pending)
        begin
            s.fin = 1'b1;
            return s;
        end
        y = tri_row;
        if (tri_vy[0] == tri_vy[2])
        begin
            xa = tri_vx[0];
            xb = tri_vx[0];
            for (int i = 1; i < 3; i++)
            begin
                if (tri_vx[i] < xa) xa = tri_vx[i];
                if (tri_vx[i] > xb) xb = tri_vx[i];
            end
        end
        else
        begin
            xa = edge_interp(tri_vx[0], tri_vx[2], y - tri_vy[0], tri_vy[2] - tri_vy[0]);
            if (y < tri_vy[1])
                xb = edge_interp(tri_vx[0], tri_vx[1], y - tri_vy[0], tri_vy[1] - tri_vy[0]);
            else
                xb = edge_interp(tri_vx[1], tri_vx[2], y - tri_vy[1], tri_vy[2] - tri_vy[1]);
            if (xa > xb)
            begin
                t  = xa;
                xa = xb;
                xb = t;
            end
        end
        s.row   = tsf_pkg::coord_t'(y);
        s.xl    = tsf_pkg::coord_t'(xa);
        s.xr    = tsf_pkg::coord_t'(xb);
        s.color = tri_color;
        s.valid = 1'b1;
        s.fin   = (y >= tri_vy[2]);
        if (s.fin)
            tri_pending = 1'b0;
        else
            tri_row = y + 1;
        return s;
    endfunction

    // command with the given op and random payload in every other field
    function automatic cmd_t rand_cmd(logic op);
        cmd_t c;
        c.op    = op;
        c.x0    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.y0    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.x1    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.y1    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.x2    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.y2    = tsf_pkg::coord_t'($urandom_range(0, 4095));
        c.color = $urandom();
        return c;
    endfunction

    // load: mostly short triangles anywhere, some flat, some with random y
    function automatic cmd_t rand_triangle();
        cmd_t c;
        int   kind;
        int   base;
        int   h;
        c    = rand_cmd(tsf_pkg::CMD_LOAD);
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // keep the fully random y values
        end
        else if (kind < 18)
        begin
            c.y1 = c.y0;
            c.y2 = c.y0;
        end
        else
        begin
            h    = $urandom_range(0, 24);
            base = $urandom_range(0, 4095 - h) - 2048;
            c.y0 = tsf_pkg::coord_t'(base + $urandom_range(0, h));
            c.y1 = tsf_pkg::coord_t'(base + $urandom_range(0, h));
            c.y2 = tsf_pkg::coord_t'(base + $urandom_range(0, h));
        end
        return c;
    endfunction

    // drive one command transfer and record what it should produce
    task automatic send_cmd(cmd_t c, logic typed, span_t want);
        span_t s;
        quiet = (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
        if (items_sent == HOLD_AT)
            hold_req = 1'b1;
        @(negedge clk);
        while (!quiet && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= c.op;
        v0_x       <= c.x0;
        v0_y       <= c.y0;
        v1_x       <= c.x1;
        v1_y       <= c.y1;
        v2_x       <= c.x2;
        v2_y       <= c.y2;
        fill_color <= c.color;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (c.op == tsf_pkg::CMD_LOAD)
            tri_load(c);
        else
        begin
            s = tri_step();
            span_q = {span_q, (typed ? want : s)};
        end
    endtask

    // lower valid, then wait for every span still owed
    task automatic drain_spans();
        @(negedge clk);
        in_valid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        cmd_t c;
        int   roll;
        int   n;
        int   ymin;
        int   ymax;
        bit   drained;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = tsf_pkg::CMD_LOAD;
        v0_x           = '0;
        v0_y           = '0;
        v1_x           = '0;
        v1_y           = '0;
        v2_x           = '0;
        v2_y           = '0;
        fill_color     = '0;
        mismatch_count = 0;
        items_sent     = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        drained        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_cmd(DIR_TAB[i].c, DIR_TAB[i].typed, DIR_TAB[i].want);

        while (items_sent < DIR_N + RAND_ITEMS)
        begin
            if (!drained && items_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                drain_spans();
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
                send_cmd(rand_cmd(tsf_pkg::CMD_STEP), 1'b0, NO_SPAN);
            else
            begin
                c = rand_triangle();
                send_cmd(c, 1'b0, NO_SPAN);
                ymin = c.y0;
                ymax = c.y0;
                if (c.y1 < ymin) ymin = c.y1;
                if (c.y2 < ymin) ymin = c.y2;
                if (c.y1 > ymax) ymax = c.y1;
                if (c.y2 > ymax) ymax = c.y2;
                // full run, cut short, or run past the end
                roll = $urandom_range(0, 99);
                if (ymax - ymin > 64)
                    n = $urandom_range(1, 4);
                else if (roll < 12)
                    n = $urandom_range(0, ymax - ymin);
                else if (roll < 24)
                    n = ymax - ymin + 1 + $urandom_range(1, 2);
                else
                    n = ymax - ymin + 1;
                for (int k = 0; k < n; k++)
                    send_cmd(rand_cmd(tsf_pkg::CMD_STEP), 1'b0, NO_SPAN);
            end
        end

        drain_spans();
        repeat (2 * STEP_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // output back pressure, with one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic check_field(string name, logic signed [32:0] want,
                               logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each span transfer with the oldest predicted span
    always @(posedge clk)
    begin : span_check
        span_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (span_q.size() == 0)
            begin
                $error("span transfer with none outstanding");
                mismatch_count++;
            end
            else
            begin
                want = span_q.pop_front();
                check_field("span_row", want.row, span_row);
                check_field("x_left", want.xl, x_left);
                check_field("x_right", want.xr, x_right);
                check_field("span_color", want.color, span_color);
                check_field("span_valid", want.valid, span_valid);
                check_field("last_span", want.fin, last_span);
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ triangle_scanline_filler.f @@
design/tsf_pkg.sv
design/tsf_edge.sv
design/triangle_scanline_filler.sv
tb/triangle_scanline_filler_tb.sv
